// ===== hw/rtl/gsd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package gsd_pkg;

	localparam int unsigned LFSR_W = 31;
	localparam int unsigned SOFT_W = 8;
	localparam int unsigned WARMUP_STEPS_DEF = 1600;
	localparam int unsigned PADDR_W = 2;
	localparam int unsigned PDATA_W = 32;
	localparam logic [PADDR_W-1:0] SEED_ADDR = 2'd0;
	localparam logic [LFSR_W-1:0] X1_INIT = 31'd1;

	typedef enum logic {
		ITEM_CONTINUE,
		ITEM_RELOAD
	} gsd_kind_t;

	typedef struct packed {
		gsd_kind_t kind;
		logic [SOFT_W-1:0] llr;
		logic last;
	} gsd_item_t;

	function automatic logic [LFSR_W-1:0] step_x1(input logic [LFSR_W-1:0] r);
		logic fb;
		fb = r[0] ^ r[3];
		return {fb, r[LFSR_W-1:1]};
	endfunction

	function automatic logic [LFSR_W-1:0] step_x2(input logic [LFSR_W-1:0] r);
		logic fb;
		fb = r[0] ^ r[1] ^ r[2] ^ r[3];
		return {fb, r[LFSR_W-1:1]};
	endfunction

	// x1 state after the warmup jump, evaluated at elaboration
	function automatic logic [LFSR_W-1:0] x1_warm(input int unsigned steps);
		logic [LFSR_W-1:0] r;
		r = X1_INIT;
		for (int unsigned k = 0; k < steps; k++) begin
			r = step_x1(r);
		end
		return r;
	endfunction

	// column i is the image of seed bit i after the warmup jump
	function automatic logic [LFSR_W*LFSR_W-1:0] x2_jump_cols(input int unsigned steps);
		logic [LFSR_W*LFSR_W-1:0] cols;
		logic [LFSR_W-1:0] r;
		cols = '0;
		for (int unsigned i = 0; i < LFSR_W; i++) begin
			r = '0;
			r[i] = 1'b1;
			for (int unsigned k = 0; k < steps; k++) begin
				r = step_x2(r);
			end
			cols[i*LFSR_W +: LFSR_W] = r;
		end
		return cols;
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/gsd_cfg.sv =====
`timescale 1ns / 1ps
`default_nettype none

module gsd_cfg #(
	parameter int unsigned WARMUP_STEPS = gsd_pkg::WARMUP_STEPS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [gsd_pkg::PADDR_W-1:0] paddr,
	input wire logic [gsd_pkg::PDATA_W-1:0] pwdata,
	output logic [gsd_pkg::PDATA_W-1:0] prdata,
	output logic pready,
	output logic [gsd_pkg::LFSR_W-1:0] jump_seed
);
	import gsd_pkg::*;

	localparam logic [LFSR_W*LFSR_W-1:0] JCOLS = x2_jump_cols(WARMUP_STEPS);

	logic [LFSR_W-1:0] seed_q;
	logic [LFSR_W-1:0] jseed_q;
	logic [LFSR_W-1:0] jseed_d;
	logic wr_en;

	assign wr_en = psel && penable && pwrite && (paddr == SEED_ADDR);
	assign pready = 1'b1;

	// seed advanced through the warmup jump, taken once at write time
	always_comb begin
		jseed_d = '0;
		for (int unsigned i = 0; i < LFSR_W; i++) begin
			if (pwdata[i]) begin
				jseed_d = jseed_d ^ JCOLS[i*LFSR_W +: LFSR_W];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= '0;
			jseed_q <= '0;
		end else if (wr_en) begin
			seed_q <= pwdata[LFSR_W-1:0];
			jseed_q <= jseed_d;
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr == SEED_ADDR) begin
			prdata = {{(PDATA_W-LFSR_W){1'b0}}, seed_q};
		end
	end

	assign jump_seed = jseed_q;

endmodule

`default_nettype wire

// ===== hw/rtl/gsd_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module gsd_front (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic signed [gsd_pkg::SOFT_W-1:0] soft_in,
	input wire logic first_item,
	input wire logic last_item,
	output gsd_pkg::gsd_item_t q_item,
	output logic q_valid,
	input wire logic q_pop
);
	import gsd_pkg::*;

	gsd_item_t mem_q [2];
	logic wr_ptr_q;
	logic rd_ptr_q;
	logic [1:0] count_q;
	logic push;
	gsd_item_t item_d;

	assign in_stall = (count_q == 2'd2);
	assign push = in_valid && !in_stall;
	assign q_valid = (count_q != 2'd0);
	assign q_item = mem_q[rd_ptr_q];

	always_comb begin
		item_d.kind = first_item ? ITEM_RELOAD : ITEM_CONTINUE;
		item_d.llr = soft_in;
		item_d.last = last_item;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= item_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (q_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, q_pop})
				2'b10: count_q <= count_q + 2'd1;
				2'b01: count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/gsd_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module gsd_back #(
	parameter int unsigned WARMUP_STEPS = gsd_pkg::WARMUP_STEPS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire gsd_pkg::gsd_item_t q_item,
	input wire logic q_valid,
	output logic q_pop,
	input wire logic [gsd_pkg::LFSR_W-1:0] jump_seed,
	output logic out_valid,
	input wire logic out_stall,
	output logic signed [gsd_pkg::SOFT_W-1:0] soft_out,
	output logic last_out
);
	import gsd_pkg::*;

	localparam logic [LFSR_W-1:0] X1_WARM = x1_warm(WARMUP_STEPS);

	logic [LFSR_W-1:0] x1_q;
	logic [LFSR_W-1:0] x2_q;
	logic [LFSR_W-1:0] x1_cur;
	logic [LFSR_W-1:0] x2_cur;
	logic out_valid_q;
	logic [SOFT_W-1:0] soft_q;
	logic last_q;
	logic cbit;

	assign q_pop = q_valid && (!out_valid_q || !out_stall);

	always_comb begin
		x1_cur = x1_q;
		x2_cur = x2_q;
		if (q_item.kind == ITEM_RELOAD) begin
			x1_cur = X1_WARM;
			x2_cur = jump_seed;
		end
		cbit = x1_cur[0] ^ x2_cur[0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x1_q <= X1_WARM;
			x2_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				x1_q <= step_x1(x1_cur);
				x2_q <= step_x2(x2_cur);
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			soft_q <= cbit ? ~q_item.llr : q_item.llr;
			last_q <= q_item.last;
		end
	end

	assign out_valid = out_valid_q;
	assign soft_out = soft_q;
	assign last_out = last_q;

endmodule

`default_nettype wire

// ===== hw/rtl/gold_sequence_llr_descrambler.sv =====
`timescale 1ns / 1ps
`default_nettype none

// channel   direction  handshake           payload
// in        input      in_valid/in_stall   soft_in, first_item, last_item
// out       output     out_valid/out_stall soft_out, last_out
// cfg       apb        psel/penable/pready seed_value at byte address 0
//
// one item per cycle unless out_stall holds; items pass the queue, then the output register
// the generator pair in the back part advances one step per item
// reset puts x1 at its warmed-up state and x2 at zero, seed reads zero
// a two-entry queue absorbs output stalls; in_stall rises only when it is full

module gold_sequence_llr_descrambler #(
	parameter int unsigned WARMUP_STEPS = gsd_pkg::WARMUP_STEPS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic signed [gsd_pkg::SOFT_W-1:0] soft_in,
	input wire logic first_item,
	input wire logic last_item,
	output logic out_valid,
	input wire logic out_stall,
	output logic signed [gsd_pkg::SOFT_W-1:0] soft_out,
	output logic last_out,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [gsd_pkg::PADDR_W-1:0] paddr,
	input wire logic [gsd_pkg::PDATA_W-1:0] pwdata,
	output logic [gsd_pkg::PDATA_W-1:0] prdata,
	output logic pready
);
	import gsd_pkg::*;

	gsd_item_t q_item;
	logic q_valid;
	logic q_pop;
	logic [LFSR_W-1:0] jump_seed;

	gsd_cfg #(
		.WARMUP_STEPS(WARMUP_STEPS)
	) u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.jump_seed(jump_seed)
	);

	gsd_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.soft_in(soft_in),
		.first_item(first_item),
		.last_item(last_item),
		.q_item(q_item),
		.q_valid(q_valid),
		.q_pop(q_pop)
	);

	gsd_back #(
		.WARMUP_STEPS(WARMUP_STEPS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_item(q_item),
		.q_valid(q_valid),
		.q_pop(q_pop),
		.jump_seed(jump_seed),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.soft_out(soft_out),
		.last_out(last_out)
	);

endmodule

`default_nettype wire

// ===== dv/tb_gold_sequence_llr_descrambler.sv =====
`timescale 1ns / 1ps

module tb_gold_sequence_llr_descrambler;
	import gsd_pkg::*;

	localparam int unsigned WARM = WARMUP_STEPS_DEF;
	localparam int unsigned HANG_LIMIT = 1000;
	localparam int unsigned PHASE_ITEMS = 290;
	localparam int unsigned N_PHASES = 5;
	localparam logic [31:0] SEED_MASK = 32'h7FFF_FFFF;

	typedef struct packed {
		logic [SOFT_W-1:0] llr;
		logic last;
	} soft_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [SOFT_W-1:0] soft_in = '0;
	logic first_item = 1'b0;
	logic last_item = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [SOFT_W-1:0] soft_out;
	logic last_out;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [PDATA_W-1:0] pwdata = '0;
	logic [PDATA_W-1:0] prdata;
	logic pready;

	gold_sequence_llr_descrambler dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.soft_in(soft_in),
		.first_item(first_item),
		.last_item(last_item),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.soft_out(soft_out),
		.last_out(last_out),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #5 clk = ~clk;

	// descrambler state as predicted from the accepted items
	logic [LFSR_W-1:0] x1_state;
	logic [LFSR_W-1:0] x2_state;
	logic [LFSR_W-1:0] seed_reg;
	soft_result_t descrambled_q[$];

	int err_count = 0;
	int items_sent = 0;
	int results_seen = 0;
	int blocks_started = 0;
	int idle_cycles = 0;
	int stall_left = 0;
	bit idle_on = 1'b1;
	soft_result_t mon_want;

	gsd_item_t directed_rows [0:17] = '{
		'{ITEM_CONTINUE, 8'h7F, 1'b0},
		'{ITEM_CONTINUE, 8'h80, 1'b0},
		'{ITEM_CONTINUE, 8'h00, 1'b0},
		'{ITEM_CONTINUE, 8'hFF, 1'b1},
		'{ITEM_RELOAD, 8'h7F, 1'b1},
		'{ITEM_RELOAD, 8'h80, 1'b0},
		'{ITEM_CONTINUE, 8'h01, 1'b0},
		'{ITEM_CONTINUE, 8'hFE, 1'b0},
		'{ITEM_CONTINUE, 8'h55, 1'b0},
		'{ITEM_CONTINUE, 8'hAA, 1'b1},
		'{ITEM_CONTINUE, 8'h7F, 1'b0},
		'{ITEM_CONTINUE, 8'h80, 1'b0},
		'{ITEM_RELOAD, 8'h00, 1'b1},
		'{ITEM_RELOAD, 8'hFF, 1'b0},
		'{ITEM_CONTINUE, 8'h0F, 1'b0},
		'{ITEM_CONTINUE, 8'hF0, 1'b1},
		'{ITEM_RELOAD, 8'hFF, 1'b1},
		'{ITEM_CONTINUE, 8'h00, 1'b1}
	};

	function automatic logic [LFSR_W-1:0] x1_advance(input logic [LFSR_W-1:0] r);
		logic [LFSR_W-1:0] fb;
		fb = {{(LFSR_W-1){1'b0}}, r[0] ^ r[3]};
		return (r >> 1) | (fb << (LFSR_W - 1));
	endfunction

	function automatic logic [LFSR_W-1:0] x2_advance(input logic [LFSR_W-1:0] r);
		logic [LFSR_W-1:0] fb;
		fb = {{(LFSR_W-1){1'b0}}, r[0] ^ r[1] ^ r[2] ^ r[3]};
		return (r >> 1) | (fb << (LFSR_W - 1));
	endfunction

	task automatic reload_generators(input logic [LFSR_W-1:0] seed);
		x1_state = X1_INIT;
		x2_state = seed;
		for (int k = 0; k < WARM; k++) begin
			x1_state = x1_advance(x1_state);
			x2_state = x2_advance(x2_state);
		end
	endtask

	task automatic descramble_item(input gsd_item_t it);
		logic c;
		soft_result_t r;
		if (it.kind == ITEM_RELOAD) begin
			reload_generators(seed_reg);
			blocks_started++;
		end
		c = x1_state[0] ^ x2_state[0];
		x1_state = x1_advance(x1_state);
		x2_state = x2_advance(x2_state);
		r.llr = c ? ~it.llr : it.llr;
		r.last = it.last;
		descrambled_q.push_back(r);
	endtask

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
		err_count++;
	endtask

	// entered and left just after a falling edge
	task automatic send_item(input gsd_item_t it);
		if (idle_on && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		in_valid <= 1'b1;
		soft_in <= it.llr;
		first_item <= (it.kind == ITEM_RELOAD);
		last_item <= it.last;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		descramble_item(it);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic apb_write(input logic [PDATA_W-1:0] data);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= SEED_ADDR;
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		seed_reg = data[LFSR_W-1:0];
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic apb_check_seed(input logic [PDATA_W-1:0] want);
		logic [PDATA_W-1:0] got;
		psel <= 1'b1;
		pwrite <= 1'b0;
		penable <= 1'b0;
		paddr <= SEED_ADDR;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		got = prdata;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		if (got !== want) report_mismatch("seed readback", got, want);
	endtask

	function automatic logic [SOFT_W-1:0] pick_soft();
		case ($urandom_range(0, 9))
			0: return 8'h7F;
			1: return 8'h80;
			2: return 8'h00;
			3: return 8'hFF;
			default: return SOFT_W'($urandom);
		endcase
	endfunction

	task automatic run_traffic(input int n_items);
		int sent;
		int len;
		gsd_item_t it;
		sent = 0;
		// a few items that carry on the block left over from the previous phase
		if ($urandom_range(0, 1)) begin
			len = $urandom_range(1, 5);
			for (int j = 0; j < len; j++) begin
				it = '{ITEM_CONTINUE, pick_soft(), 1'b0};
				send_item(it);
			end
			sent += len;
		end
		while (sent < n_items) begin
			if ($urandom_range(0, 6) == 0) begin
				len = $urandom_range(1, 6);
				if (len > n_items - sent) len = n_items - sent;
				for (int j = 0; j < len; j++) begin
					it.kind = $urandom_range(0, 1) ? ITEM_RELOAD : ITEM_CONTINUE;
					it.llr = pick_soft();
					it.last = 1'($urandom_range(0, 1));
					send_item(it);
				end
			end else begin
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 120)
					: $urandom_range(1, 24);
				if (len > n_items - sent) len = n_items - sent;
				for (int j = 0; j < len; j++) begin
					it.kind = (j == 0) ? ITEM_RELOAD : ITEM_CONTINUE;
					it.llr = pick_soft();
					it.last = (j == len - 1);
					send_item(it);
				end
			end
			sent += len;
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (descrambled_q.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// output stall bursts
	always @(negedge clk) begin
		if (stall_left != 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else if (idle_on && $urandom_range(0, 5) == 0) begin
			stall_left = $urandom_range(0, 3);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (descrambled_q.size() == 0) begin
				report_mismatch("item with nothing pending",
					{23'd0, soft_out, last_out}, 32'd0);
			end else begin
				mon_want = descrambled_q.pop_front();
				if (soft_out !== mon_want.llr) begin
					report_mismatch("soft_out", {24'd0, soft_out}, {24'd0, mon_want.llr});
				end
				if (last_out !== mon_want.last) begin
					report_mismatch("last_out", {31'd0, last_out}, {31'd0, mon_want.last});
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || psel) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= HANG_LIMIT) begin
				$display("no progress for %0d cycles, %0d items pending",
					idle_cycles, descrambled_q.size());
				$display("tb_gold_sequence_llr_descrambler: FAIL");
				$finish;
			end
		end
	end

	initial begin
		logic [PDATA_W-1:0] seed_words [0:N_PHASES-1];
		seed_words[0] = 32'hFFFF_FFFF;
		seed_words[1] = 32'h0000_0000;
		seed_words[2] = 32'h8000_0001;
		seed_words[3] = $urandom;
		seed_words[4] = $urandom;
		seed_reg = '0;
		reload_generators('0);
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		apb_check_seed('0);

		// reset state, seed zero
		foreach (directed_rows[i]) send_item(directed_rows[i]);

		for (int ph = 0; ph < N_PHASES; ph++) begin
			drain();
			apb_write(seed_words[ph]);
			apb_check_seed(seed_words[ph] & SEED_MASK);
			idle_on = (ph == 0 || ph == 1 || ph == 3);
			run_traffic(PHASE_ITEMS);
		end

		in_valid <= 1'b0;
		while (descrambled_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		$display("sent %0d soft bits in %0d block starts, %0d descrambled items checked",
			items_sent, blocks_started, results_seen);
		$display("seed settings: reset, all ones, zero, sparse and two random values");
		if (err_count == 0) begin
			$display("tb_gold_sequence_llr_descrambler: PASS");
		end else begin
			$display("%0d mismatches", err_count);
			$display("tb_gold_sequence_llr_descrambler: FAIL");
		end
		$finish;
	end

endmodule
